// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Check that a trigger implies a property in the same cycle.
`define ASSERT_IMPL(label, trig, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (trig) |-> (prop)) else $error(msg);

// Check that a trigger implies a property in the next cycle.
`define ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (trig) |=> (prop)) else $error(msg);

`endif

// ----- src/sc2a_pkg.sv -----
// ----------------------------------------------------------------------------
// sc2a_pkg
// Types, constants and set-1 keymap tables for the scancode decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sc2a_pkg;

    // Character ring geometry
    localparam int RING_DEPTH = 256;
    localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    // Output queue geometry
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    // Scancode constants
    localparam logic [7:0] SC_RELEASE = 8'h80;
    localparam logic [6:0] SC_KEYMASK = 7'h7F;
    localparam logic [6:0] SC_LSHIFT  = 7'h2A;
    localparam logic [6:0] SC_RSHIFT  = 7'h36;
    localparam logic [6:0] SC_CAPS    = 7'h3A;
    localparam int         KEYMAP_LEN = 59;

    // Command codes
    localparam logic CMD_SCANCODE = 1'b0;
    localparam logic CMD_READ     = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] scancode;
    } in_item_t;

    typedef struct packed {
        logic       char_valid;
        logic [6:0] char_out;
        logic       not_empty;
        logic       overflow;
    } out_item_t;

    // Flags carried alongside the ring read
    typedef struct packed {
        logic valid;
        logic char_valid;
        logic not_empty;
        logic overflow;
    } st1_t;

    typedef logic [6:0] keymap_t [64];

    // US layout, unshifted; codes past the table read as zero
    localparam keymap_t KEYMAP_LO = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    // US layout, shifted
    localparam keymap_t KEYMAP_HI = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    // Advance a ring index with wrap at the ring depth
    function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] idx);
        logic [RING_AW-1:0] res;
        if (idx == RING_AW'(RING_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = idx + 1'b1;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- src/scancode_to_ascii_key_fifo.sv -----
// ----------------------------------------------------------------------------
// scancode_to_ascii_key_fifo
// Set-1 scancode decoder that queues ASCII characters in a ring buffer.
// ----------------------------------------------------------------------------
// Each transaction is either a raw set-1 scancode byte (cmd = 0) or a request
// to pop one character (cmd = 1), and each returns exactly one result.
// Shift make/break codes set and clear shift, the caps lock make code toggles
// caps, and other make codes below 59 are mapped through the US keymap and
// pushed into a 256-entry ring (255 usable); a push into a full ring is
// dropped and reported by overflow. The block takes one transaction per
// clock cycle while s_ready is high. Each result is registered first by the
// synchronous ring read and then by the four-entry output queue before it
// is offered on m_valid; s_ready stays high while fewer than four results
// are held in the output queue and the read stage together.
`default_nettype none

`include "assert_macros.svh"

module scancode_to_ascii_key_fifo (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output      logic                 s_ready,
    input  wire sc2a_pkg::in_item_t   s_item,
    output      logic                 m_valid,
    input  wire logic                 m_ready,
    output      sc2a_pkg::out_item_t  m_item
);
    import sc2a_pkg::*;

    // Decoder state
    logic               shift_reg, shift_next;
    logic               caps_reg, caps_next;
    logic [RING_AW-1:0] rd_idx_reg, rd_idx_next;
    logic [RING_AW-1:0] wr_idx_reg, wr_idx_next;

    // Ring memory and its registered read port
    logic [6:0]         ring_mem [RING_DEPTH];
    logic [6:0]         ring_rdata_reg;

    // Stage behind the ring read
    st1_t               st1_reg, st1_next;

    // Output queue
    out_item_t          oq_data_reg [OQ_DEPTH];
    logic [OQ_AW-1:0]   oq_wr_ptr_reg;
    logic [OQ_AW-1:0]   oq_rd_ptr_reg;
    logic [OQ_CW-1:0]   oq_cnt_reg, oq_cnt_next;

    logic               s_accept;
    logic               m_accept;
    logic               is_read;
    logic               ring_hit;
    logic               pop;
    logic               is_release;
    logic               is_shift_key;
    logic               in_table;
    logic [6:0]         key_char;
    logic               ring_full;
    logic               want_push;
    logic               push;
    logic [OQ_CW:0]     occupancy;
    out_item_t          oq_in;

    // Accept while the queue plus the read stage leave room
    assign occupancy = {1'b0, oq_cnt_reg} + (OQ_CW + 1)'(st1_reg.valid);
    assign s_ready   = (occupancy < (OQ_CW + 1)'(OQ_DEPTH));
    assign s_accept  = s_valid && s_ready;
    assign m_valid   = (oq_cnt_reg != '0);
    assign m_accept  = m_valid && m_ready;
    assign m_item    = oq_data_reg[oq_rd_ptr_reg];

    // Decode the transaction
    assign is_read      = (s_item.cmd == CMD_READ);
    assign ring_hit     = (rd_idx_reg != wr_idx_reg);
    assign pop          = is_read && ring_hit;
    assign is_release   = ((s_item.scancode & SC_RELEASE) != 8'h00);
    assign is_shift_key = (s_item.scancode[6:0] == SC_LSHIFT) ||
                          (s_item.scancode[6:0] == SC_RSHIFT);
    assign in_table     = (s_item.scancode < 8'(KEYMAP_LEN));
    assign key_char     = (shift_reg ^ caps_reg) ? KEYMAP_HI[s_item.scancode[5:0]]
                                                 : KEYMAP_LO[s_item.scancode[5:0]];
    assign ring_full    = (ring_next(wr_idx_reg) == rd_idx_reg);
    assign want_push    = !is_read && !is_release && !is_shift_key &&
                          (s_item.scancode[6:0] != SC_CAPS) && in_table &&
                          (key_char != 7'h00);
    assign push         = want_push && !ring_full;

    // Next decoder state and flags for the read stage
    always_comb begin
        shift_next  = shift_reg;
        caps_next   = caps_reg;
        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        st1_next    = '0;
        if (s_accept) begin
            if (pop) begin
                rd_idx_next = ring_next(rd_idx_reg);
            end
            if (!is_read && is_shift_key) begin
                shift_next = !is_release;
            end
            if (!is_read && !is_release && (s_item.scancode[6:0] == SC_CAPS)) begin
                caps_next = !caps_reg;
            end
            if (push) begin
                wr_idx_next = ring_next(wr_idx_reg);
            end
            st1_next.valid      = 1'b1;
            st1_next.char_valid = pop;
            st1_next.not_empty  = (rd_idx_next != wr_idx_next);
            st1_next.overflow   = want_push && ring_full;
        end
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg  <= 1'b0;
            caps_reg   <= 1'b0;
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
            st1_reg    <= '0;
        end else begin
            shift_reg  <= shift_next;
            caps_reg   <= caps_next;
            rd_idx_reg <= rd_idx_next;
            wr_idx_reg <= wr_idx_next;
            st1_reg    <= st1_next;
        end
    end

    // Write and read the ring
    always_ff @(posedge aclk) begin
        if (s_accept && push) begin
            ring_mem[wr_idx_reg] <= key_char;
        end
        if (s_accept && pop) begin
            ring_rdata_reg <= ring_mem[rd_idx_reg];
        end
    end

    // Assemble the result from flags and ring data
    always_comb begin
        oq_in            = '0;
        oq_in.char_valid = st1_reg.char_valid;
        oq_in.char_out   = st1_reg.char_valid ? ring_rdata_reg : 7'h00;
        oq_in.not_empty  = st1_reg.not_empty;
        oq_in.overflow   = st1_reg.overflow;
    end

    // Count queued results
    always_comb begin
        oq_cnt_next = oq_cnt_reg;
        case ({st1_reg.valid, m_accept})
            2'b10:   oq_cnt_next = oq_cnt_reg + 1'b1;
            2'b01:   oq_cnt_next = oq_cnt_reg - 1'b1;
            default: oq_cnt_next = oq_cnt_reg;
        endcase
    end

    // Advance the output queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oq_wr_ptr_reg <= '0;
            oq_rd_ptr_reg <= '0;
            oq_cnt_reg    <= '0;
        end else begin
            if (st1_reg.valid) begin
                oq_wr_ptr_reg <= oq_wr_ptr_reg + 1'b1;
            end
            if (m_accept) begin
                oq_rd_ptr_reg <= oq_rd_ptr_reg + 1'b1;
            end
            oq_cnt_reg <= oq_cnt_next;
        end
    end

    // Store results into the queue
    always_ff @(posedge aclk) begin
        if (st1_reg.valid) begin
            oq_data_reg[oq_wr_ptr_reg] <= oq_in;
        end
    end

    // Checks
    `ASSERT_ALWAYS(a_oq_no_overrun, occupancy <= (OQ_CW + 1)'(OQ_DEPTH),
        "output queue plus read stage exceed capacity")
    `ASSERT_NEXT(a_pop_reaches_stage, s_accept && pop,
        st1_reg.valid && st1_reg.char_valid, "accepted pop lost before read stage")
    `ASSERT_IMPL(a_char_zero_when_empty, m_valid && !m_item.char_valid,
        m_item.char_out == 7'h00, "char_out nonzero without a popped character")
    `ASSERT_IMPL(a_ovf_not_on_read, m_valid && m_item.overflow,
        !m_item.char_valid, "overflow reported on a read result")
    `ASSERT_NEXT(a_push_sets_not_empty, s_accept && push,
        st1_reg.not_empty, "push left the ring reported as empty")

endmodule

`default_nettype wire
